// ----- src/pwd_pkg.sv -----
// Shared types and constants for the pose waypoint decimator.
// Used by pwd_ctrl, pwd_datapath and the top level; depends on nothing.
package pwd_pkg;

   // Register indexes on the write port
   localparam logic [1:0] CSR_DIST  = 2'd0;
   localparam logic [1:0] CSR_TIME  = 2'd1;
   localparam logic [1:0] CSR_ANGLE = 2'd2;

   localparam logic [31:0] DIST_RESET  = 32'd65536;
   localparam logic [31:0] TIME_RESET  = 32'd1000000;
   localparam logic [15:0] ANGLE_RESET = 16'd0;

   // Path length saturates here (Q24.16)
   localparam logic [39:0] ACCUM_MAX = {40{1'b1}};
   localparam int unsigned ROOT_STEPS = 32;

   // Binary angles for the pre-rotation (2^32 is a full turn)
   localparam logic [31:0] ANG_HALF_PI = 32'h4000_0000;
   localparam logic [31:0] ANG_NEG_HALF_PI = 32'hC000_0000;

   // Controller states, one-hot
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PROD   = 7'b0000010,
      S_PRE    = 7'b0000100,
      S_SQ     = 7'b0001000,
      S_RINIT  = 7'b0010000,
      S_ROOT   = 7'b0100000,
      S_DECIDE = 7'b1000000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic prod;
      logic pre;
      logic sq_step;
      logic root_init;
      logic root_step;
      logic commit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic sq_last;
      logic root_done;
      logic cordic_done;
      logic out_free;
   } sts_type;

   // arctan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2F9;
         5'd15:   a = 32'h0000517C;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A2F;
         5'd19:   a = 32'h00000517;
         5'd20:   a = 32'h0000028B;
         5'd21:   a = 32'h00000145;
         5'd22:   a = 32'h000000A2;
         5'd23:   a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ----- src/pwd_ctrl.sv -----
// Sequencing state machine for the pose waypoint decimator.
// Depends on pwd_pkg; drives commands into pwd_datapath.
module pwd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pwd_pkg::sts_type sts,
   output pwd_pkg::cmd_type cmd
);
   import pwd_pkg::*;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_PRE;
         end
         S_PRE: begin
            cmd.pre = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            if (sts.sq_last) state_in = S_RINIT;
         end
         S_RINIT: begin
            cmd.root_init = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = !sts.root_done;
            if (sts.root_done && sts.cordic_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   // Checks
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free) else $error("commit while output busy");
   a_decide_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> sts.cordic_done && sts.root_done)
      else $error("decide before units done");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_PROD) else $error("load did not start work");

endmodule

// ----- src/pwd_datapath.sv -----
// Datapath: CORDIC yaw, sum of squares, square root, thresholds, output word.
// Depends on pwd_pkg; sequenced by pwd_ctrl.
module pwd_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic [47:0]        req_stamp_us,
   input  pwd_pkg::cmd_type   cmd,
   output pwd_pkg::sts_type   sts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_wp_x,
   output logic signed [31:0] rsp_wp_y,
   output logic signed [31:0] rsp_wp_z,
   output logic signed [15:0] rsp_wp_qx,
   output logic signed [15:0] rsp_wp_qy,
   output logic signed [15:0] rsp_wp_qz,
   output logic signed [15:0] rsp_wp_qw,
   output logic [47:0]        rsp_wp_stamp_us,
   output logic               rsp_is_first,
   output logic               rsp_by_distance,
   output logic               rsp_by_time,
   output logic               rsp_by_angle
);
   import pwd_pkg::*;

   localparam int CW = $clog2(CORDIC_STEPS + 1);

   // Configuration registers
   logic [31:0] dist_thr_ff, time_thr_ff;
   logic [15:0] ang_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_thr_ff <= DIST_RESET;
         time_thr_ff <= TIME_RESET;
         ang_thr_ff  <= ANGLE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIST:  dist_thr_ff <= csr_data;
            CSR_TIME:  time_thr_ff <= csr_data;
            CSR_ANGLE: ang_thr_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Block state
   logic               seen_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [39:0]        accum_ff;
   logic [47:0]        kept_stamp_ff;
   logic [15:0]        kept_yaw_ff;

   // Captured sample
   logic signed [31:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic [47:0]        stamp_ff;
   logic [32:0]        mag_ff [3];

   logic signed [32:0] dx, dy, dz;
   assign dx = 33'(req_pos_x) - 33'(prev_x_ff);
   assign dy = 33'(req_pos_y) - 33'(prev_y_ff);
   assign dz = 33'(req_pos_z) - 33'(prev_z_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_pos_x;
         cur_y_ff <= req_pos_y;
         cur_z_ff <= req_pos_z;
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
         qw_ff <= req_quat_w;
         stamp_ff <= req_stamp_us;
         mag_ff[0] <= dx[32] ? 33'(-dx) : 33'(dx);
         mag_ff[1] <= dy[32] ? 33'(-dy) : 33'(dy);
         mag_ff[2] <= dz[32] ? 33'(-dz) : 33'(dz);
      end
   end

   // Quaternion products
   logic signed [31:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         p_wz_ff <= qw_ff * qz_ff;
         p_xy_ff <= qx_ff * qy_ff;
         p_yy_ff <= qy_ff * qy_ff;
         p_zz_ff <= qz_ff * qz_ff;
      end
   end

   // atan2 operands and pre-rotation
   logic signed [35:0] num, den;
   assign num = (36'(p_wz_ff) + 36'(p_xy_ff)) <<< 1;
   assign den = 36'sd1073741824 - ((36'(p_yy_ff) + 36'(p_zz_ff)) <<< 1);

   logic signed [35:0] cx_ff, cy_ff;
   logic [31:0]        cz_ff;
   logic [CW-1:0]      ccnt_ff;
   logic               czero_ff;
   logic               cbusy;
   assign cbusy = (ccnt_ff < CW'(CORDIC_STEPS));

   logic signed [35:0] sx, sy;
   assign sx = cx_ff >>> ccnt_ff;
   assign sy = cy_ff >>> ccnt_ff;

   // Vectoring CORDIC, one iteration a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         ccnt_ff <= CW'(CORDIC_STEPS);
      end else if (cmd.pre) begin
         ccnt_ff <= '0;
         czero_ff <= (num == '0) && (den == '0);
         if (den < 0) begin
            if (num >= 0) begin
               cx_ff <= num;
               cy_ff <= -den;
               cz_ff <= ANG_HALF_PI;
            end else begin
               cx_ff <= -num;
               cy_ff <= den;
               cz_ff <= ANG_NEG_HALF_PI;
            end
         end else begin
            cx_ff <= den;
            cy_ff <= num;
            cz_ff <= '0;
         end
      end else if (cbusy) begin
         ccnt_ff <= ccnt_ff + 1'b1;
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + sy;
            cy_ff <= cy_ff - sx;
            cz_ff <= cz_ff + atan_angle(5'(ccnt_ff));
         end else begin
            cx_ff <= cx_ff - sy;
            cy_ff <= cy_ff + sx;
            cz_ff <= cz_ff - atan_angle(5'(ccnt_ff));
         end
      end
   end

   logic [31:0] zr;
   logic [15:0] yaw;
   assign zr  = cz_ff + 32'h0000_8000;
   assign yaw = czero_ff ? 16'd0 : zr[31:16];

   // Sum of squares: three 17x17 partial products per axis
   logic [1:0]  axis_ff, part_ff;
   logic [65:0] sum_ff;
   logic [32:0] msel;
   logic [16:0] ma, mb;
   logic [33:0] pp;
   logic [65:0] pp_sh;

   assign msel = mag_ff[axis_ff];
   always_comb begin
      case (part_ff)
         2'd0: begin
            ma = msel[32:16];
            mb = msel[32:16];
         end
         2'd1: begin
            ma = msel[32:16];
            mb = {1'b0, msel[15:0]};
         end
         default: begin
            ma = {1'b0, msel[15:0]};
            mb = {1'b0, msel[15:0]};
         end
      endcase
   end
   assign pp = ma * mb;
   always_comb begin
      case (part_ff)
         2'd0:    pp_sh = {pp, 32'd0};
         2'd1:    pp_sh = {15'd0, pp, 17'd0};
         default: pp_sh = {32'd0, pp};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         axis_ff <= '0;
         part_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.sq_step) begin
         sum_ff <= sum_ff + pp_sh;
         if (part_ff == 2'd2) begin
            part_ff <= '0;
            axis_ff <= axis_ff + 1'b1;
         end else begin
            part_ff <= part_ff + 1'b1;
         end
      end
   end

   // Integer square root, one result bit a cycle
   logic [63:0] rn_ff, rres_ff, rbit_ff, rsum;
   logic [5:0]  rcnt_ff;
   logic        huge_ff;
   assign rsum = rres_ff + rbit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rcnt_ff <= 6'(ROOT_STEPS);
      end else if (cmd.root_init) begin
         rn_ff   <= sum_ff[63:0];
         rres_ff <= '0;
         rbit_ff <= 64'h4000_0000_0000_0000;
         rcnt_ff <= '0;
         huge_ff <= (sum_ff[65:64] != 2'd0);
      end else if (cmd.root_step) begin
         rcnt_ff <= rcnt_ff + 1'b1;
         rbit_ff <= rbit_ff >> 2;
         if (rn_ff >= rsum) begin
            rn_ff   <= rn_ff - rsum;
            rres_ff <= (rres_ff >> 1) + rbit_ff;
         end else begin
            rres_ff <= rres_ff >> 1;
         end
      end
   end

   // Threshold tests
   logic [32:0] step;
   logic [40:0] path_sum;
   logic [39:0] path_in;
   logic [47:0] elapsed;
   logic [15:0] dyaw_raw;
   logic [16:0] dyaw;
   logic        first, tl, tt, ta, emit;

   assign step     = huge_ff ? 33'h1_0000_0000 : rres_ff[32:0];
   assign path_sum = 41'(accum_ff) + 41'(step);
   assign path_in  = path_sum[40] ? ACCUM_MAX : path_sum[39:0];
   assign elapsed  = stamp_ff - kept_stamp_ff;
   assign dyaw_raw = yaw - kept_yaw_ff;
   assign dyaw     = dyaw_raw[15] ? 17'(-{1'b1, dyaw_raw}) : {1'b0, dyaw_raw};
   assign first    = !seen_ff;
   assign tl = !first && (path_in >= 40'(dist_thr_ff));
   assign tt = !first && (stamp_ff >= kept_stamp_ff) && (elapsed >= 48'(time_thr_ff));
   assign ta = !first && (ang_thr_ff != '0) && (dyaw >= 17'(ang_thr_ff));
   assign emit = first || tl || tt || ta;

   // State update at commit
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_z_ff <= '0;
         accum_ff <= '0;
         kept_stamp_ff <= '0;
         kept_yaw_ff <= '0;
      end else if (cmd.commit) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
         prev_z_ff <= cur_z_ff;
         if (emit) begin
            seen_ff <= 1'b1;
            accum_ff <= '0;
            kept_stamp_ff <= stamp_ff;
            kept_yaw_ff <= yaw;
         end else begin
            accum_ff <= path_in;
         end
      end
   end

   // Output word register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.commit && emit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && emit) begin
         rsp_wp_x <= cur_x_ff;
         rsp_wp_y <= cur_y_ff;
         rsp_wp_z <= cur_z_ff;
         rsp_wp_qx <= qx_ff;
         rsp_wp_qy <= qy_ff;
         rsp_wp_qz <= qz_ff;
         rsp_wp_qw <= qw_ff;
         rsp_wp_stamp_us <= stamp_ff;
         rsp_is_first <= first;
         rsp_by_distance <= tl;
         rsp_by_time <= tt;
         rsp_by_angle <= ta;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign sts.sq_last     = (axis_ff == 2'd2) && (part_ff == 2'd2);
   assign sts.root_done   = (rcnt_ff == 6'(ROOT_STEPS));
   assign sts.cordic_done = !cbusy;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   // Checks
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && emit |=> accum_ff == '0) else $error("accumulator not cleared");
   a_first_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && first |-> !tl && !tt && !ta) else $error("flags on first word");
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.root_done && sts.cordic_done) else $error("load while busy");

endmodule

// ----- src/pose_waypoint_decimator.sv -----
// Top level of the pose waypoint decimator.
// Depends on pwd_pkg, pwd_ctrl and pwd_datapath.
//
// Usage: one pose word enters on the req_ channel (valid/stall) and is kept
// or dropped. A kept word leaves on the rsp_ channel with its trigger flags.
// The first word after reset is always kept; later words are kept when the
// path length, elapsed time or yaw change reaches its csr_ threshold (a zero
// angle threshold turns the yaw test off). Registers are written over csr_
// (index 0 distance, 1 time, 2 angle); the user must do so only while the
// block is idle, which the block itself does not enforce. An accepted word
// runs through the quaternion products, the pre-rotation, the nine partial
// products for the squared step length, the root set-up and the 32-step
// square root, then the decision into the result register; the CORDIC yaw
// runs alongside. One word is in flight at a time.
// req_stall is high while a word is being worked on.
// Reset (synchronous) clears the thresholds to defaults and all history.
// While the receiver stalls, the held result stays; the next word may be
// accepted and worked on, and waits at its decision step until the output
// register frees.
module pose_waypoint_decimator #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic [47:0]        req_stamp_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_wp_x,
   output logic signed [31:0] rsp_wp_y,
   output logic signed [31:0] rsp_wp_z,
   output logic signed [15:0] rsp_wp_qx,
   output logic signed [15:0] rsp_wp_qy,
   output logic signed [15:0] rsp_wp_qz,
   output logic signed [15:0] rsp_wp_qw,
   output logic [47:0]        rsp_wp_stamp_us,
   output logic               rsp_is_first,
   output logic               rsp_by_distance,
   output logic               rsp_by_time,
   output logic               rsp_by_angle
);
   import pwd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pwd_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .req_quat_w       (req_quat_w),
      .req_stamp_us     (req_stamp_us),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_wp_x         (rsp_wp_x),
      .rsp_wp_y         (rsp_wp_y),
      .rsp_wp_z         (rsp_wp_z),
      .rsp_wp_qx        (rsp_wp_qx),
      .rsp_wp_qy        (rsp_wp_qy),
      .rsp_wp_qz        (rsp_wp_qz),
      .rsp_wp_qw        (rsp_wp_qw),
      .rsp_wp_stamp_us  (rsp_wp_stamp_us),
      .rsp_is_first     (rsp_is_first),
      .rsp_by_distance  (rsp_by_distance),
      .rsp_by_time      (rsp_by_time),
      .rsp_by_angle     (rsp_by_angle)
   );

endmodule

// ----- dv/tb_pose_waypoint_decimator.sv -----
// Self-checking testbench for pose_waypoint_decimator: predicts kept waypoints
// and trigger flags from the thresholds and pose history. Depends on pwd_pkg.
module tb_pose_waypoint_decimator;
   import pwd_pkg::*;

   localparam int LATENCY = 60;
   localparam int WATCHDOG_LIMIT = 20000;
   // register index with no register behind it
   localparam logic [1:0] CSR_NONE = 2'd3;

   typedef struct packed {
      logic signed [31:0] x, y, z;
      logic signed [15:0] qx, qy, qz, qw;
      logic [47:0] stamp;
   } pose_word;

   typedef struct packed {
      logic signed [31:0] x, y, z;
      logic signed [15:0] qx, qy, qz, qw;
      logic [47:0] stamp;
      logic first, by_dist, by_time, by_angle;
   } waypoint_word;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic [47:0] req_stamp_us = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_wp_x, rsp_wp_y, rsp_wp_z;
   logic signed [15:0] rsp_wp_qx, rsp_wp_qy, rsp_wp_qz, rsp_wp_qw;
   logic [47:0] rsp_wp_stamp_us;
   logic rsp_is_first, rsp_by_distance, rsp_by_time, rsp_by_angle;

   pose_waypoint_decimator DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [31:0] dist_thr, time_thr;
   logic [15:0] angle_thr;
   logic seen_any;
   logic signed [31:0] last_x, last_y, last_z;
   logic [39:0] path_len;
   logic [47:0] kept_stamp;
   logic [15:0] kept_yaw;

   waypoint_word waypoints_due[$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 0;

   const logic [31:0] atan_steps[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   // yaw from quaternion, vectoring CORDIC; >>> floors as required
   function automatic logic [15:0] yaw_angle(pose_word p);
      longint num, den, vx, vy, nx;
      logic [31:0] ang;
      num = 2 * (longint'(p.qw) * p.qz + longint'(p.qx) * p.qy);
      den = (longint'(1) << 30) - 2 * (longint'(p.qy) * p.qy + longint'(p.qz) * p.qz);
      ang = '0;
      if (num == 0 && den == 0) return '0;
      if (den < 0) begin
         if (num >= 0) begin
            vx = num; vy = -den; ang = ANG_HALF_PI;
         end else begin
            vx = -num; vy = den; ang = ANG_NEG_HALF_PI;
         end
      end else begin
         vx = den; vy = num;
      end
      for (int i = 0; i < 16; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i); vy = vy - (vx >>> i); ang += atan_steps[i];
         end else begin
            nx = vx - (vy >>> i); vy = vy + (vx >>> i); ang -= atan_steps[i];
         end
         vx = nx;
      end
      ang = ang + 32'h8000;
      return ang[31:16];
   endfunction

   // step length: floor sqrt of squared distance, 2^32 on overflow
   function automatic logic [63:0] step_length(pose_word p);
      logic [64:0] sum;
      logic [63:0] rem, root, bitv;
      longint d[3];
      logic [32:0] mag;
      d[0] = longint'(p.x) - last_x;
      d[1] = longint'(p.y) - last_y;
      d[2] = longint'(p.z) - last_z;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         mag = 33'(d[k] < 0 ? -d[k] : d[k]);
         sum += 65'(mag) * 65'(mag);
         if (sum[64]) return 64'h1_0000_0000;
      end
      rem = sum[63:0]; root = '0; bitv = 64'h1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv; root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   task automatic predict_waypoint(pose_word p);
      logic [15:0] yaw, dy;
      logic [63:0] acc;
      logic first, td, tt, ta;
      waypoint_word w;
      yaw = yaw_angle(p);
      first = !seen_any; td = 0; tt = 0; ta = 0;
      if (!first) begin
         acc = 64'(path_len) + step_length(p);
         path_len = acc > 64'(ACCUM_MAX) ? ACCUM_MAX : acc[39:0];
         dy = yaw - kept_yaw;
         if (dy[15]) dy = -dy;
         td = path_len >= 40'(dist_thr);
         tt = p.stamp >= kept_stamp && (p.stamp - kept_stamp) >= 48'(time_thr);
         ta = angle_thr != 0 && 17'(dy) >= 17'(angle_thr);
      end
      last_x = p.x; last_y = p.y; last_z = p.z;
      if (first || td || tt || ta) begin
         seen_any = 1; path_len = '0; kept_stamp = p.stamp; kept_yaw = yaw;
         w = '{p.x, p.y, p.z, p.qx, p.qy, p.qz, p.qw, p.stamp, first, td, tt, ta};
         waypoints_due.push_back(w);
      end
   endtask

   task automatic send_pose(pose_word p);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      {req_pos_x, req_pos_y, req_pos_z, req_quat_x, req_quat_y, req_quat_z,
       req_quat_w, req_stamp_us} <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_waypoint(p);
      req_valid <= 0;
      // block is still busy with this word anyway
      @(posedge clock);
   endtask

   task automatic drain();
      while (waypoints_due.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_write_enable <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_DIST:  dist_thr = val;
         CSR_TIME:  time_thr = val;
         CSR_ANGLE: angle_thr = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic pose_word random_pose(logic [47:0] stamp, int span);
      pose_word p;
      p.x = last_x + $signed($urandom_range(2 * span)) - span;
      p.y = last_y + $signed($urandom_range(2 * span)) - span;
      p.z = last_z + $signed($urandom_range(2 * span)) - span;
      {p.qx, p.qy} = $urandom; {p.qz, p.qw} = $urandom;
      p.stamp = stamp;
      if ($urandom_range(19) == 0) begin
         p.x = $urandom; p.y = $urandom; p.z = $urandom;
         p.stamp = 48'({$urandom, $urandom});
      end
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      waypoint_word e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (waypoints_due.size() == 0) begin
            $error("unexpected waypoint x=%h", rsp_wp_x);
            errors++;
         end else begin
            e = waypoints_due.pop_front();
            if (rsp_wp_x !== e.x) begin $error("wp_x exp %h got %h", e.x, rsp_wp_x); errors++; end
            if (rsp_wp_y !== e.y) begin $error("wp_y exp %h got %h", e.y, rsp_wp_y); errors++; end
            if (rsp_wp_z !== e.z) begin $error("wp_z exp %h got %h", e.z, rsp_wp_z); errors++; end
            if (rsp_wp_qx !== e.qx) begin $error("wp_qx exp %h got %h", e.qx, rsp_wp_qx); errors++; end
            if (rsp_wp_qy !== e.qy) begin $error("wp_qy exp %h got %h", e.qy, rsp_wp_qy); errors++; end
            if (rsp_wp_qz !== e.qz) begin $error("wp_qz exp %h got %h", e.qz, rsp_wp_qz); errors++; end
            if (rsp_wp_qw !== e.qw) begin $error("wp_qw exp %h got %h", e.qw, rsp_wp_qw); errors++; end
            if (rsp_wp_stamp_us !== e.stamp) begin
               $error("wp_stamp_us exp %h got %h", e.stamp, rsp_wp_stamp_us); errors++;
            end
            if (rsp_is_first !== e.first) begin
               $error("is_first exp %b got %b", e.first, rsp_is_first); errors++;
            end
            if (rsp_by_distance !== e.by_dist) begin
               $error("by_distance exp %b got %b", e.by_dist, rsp_by_distance); errors++;
            end
            if (rsp_by_time !== e.by_time) begin
               $error("by_time exp %b got %b", e.by_time, rsp_by_time); errors++;
            end
            if (rsp_by_angle !== e.by_angle) begin
               $error("by_angle exp %b got %b", e.by_angle, rsp_by_angle); errors++;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on accepted words and delivered results
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("pose_waypoint_decimator test failed");
         $finish;
      end
   end

   task automatic test_directed();
      pose_word p;
      // first word, extremes of position and quaternion
      p = '{32'sh7FFFFFFF, 32'sh80000000, 0, 16'sh7FFF, 16'sh8000, 0, 0, 48'hFFFF_FFFF_FFFF};
      send_pose(p);
      // huge step, time backwards
      p = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 16'sh7FFF,
            16'sh7FFF, 16'sh8000, 48'd0};
      send_pose(p);
      // zero quaternion, no move
      p = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 48'd10};
      send_pose(p);
      // small steps until distance fires
      for (int i = 1; i <= 6; i++) begin
         p = '{32'sh80000000 + i * 20000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0,
               16'sh7FFF, 48'd10 + i};
         send_pose(p);
      end
      drain();
      // yaw turns, each quaternion sign
      write_reg(CSR_ANGLE, 32'd32768);
      write_reg(CSR_DIST, 32'hFFFF_FFFF);
      write_reg(CSR_TIME, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) begin
         p = '{last_x, last_y, last_z, 0, 0, (i % 2) ? 16'sh7FFF : 16'sh8001,
               (i < 3) ? 16'sh0000 : 16'sh7FFF, 48'd100 + i};
         send_pose(p);
      end
      drain();
      // zero distance and time thresholds: every word fires
      write_reg(CSR_DIST, 32'd0);
      write_reg(CSR_TIME, 32'd0);
      write_reg(CSR_ANGLE, 32'd1);
      write_reg(CSR_NONE, 32'hDEAD_BEEF);
      for (int i = 0; i < 5; i++) send_pose(random_pose(48'd200 + i, 1000));
      drain();
   endtask

   task automatic test_random(int count, int sidle, int ridle);
      logic [47:0] stamp;
      send_idle_pct = sidle; recv_idle_pct = ridle;
      write_reg(CSR_DIST, $urandom_range(400000));
      write_reg(CSR_TIME, $urandom_range(5000));
      write_reg(CSR_ANGLE, $urandom_range(32768, 0) >> $urandom_range(4));
      stamp = kept_stamp;
      for (int i = 0; i < count; i++) begin
         stamp += $urandom_range(400);
         send_pose(random_pose(stamp, 70000));
      end
      drain();
   endtask

   task automatic test_backpressure();
      logic [47:0] stamp;
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(CSR_DIST, 32'd0);
      hold_off = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         begin
            stamp = kept_stamp;
            for (int i = 0; i < 8; i++) send_pose(random_pose(stamp + i, 100));
         end
      join
      drain();
      // sender waits for all results before going on
      send_pose(random_pose(stamp + 20, 100));
      drain();
   endtask

   initial begin
      dist_thr = DIST_RESET; time_thr = TIME_RESET; angle_thr = ANGLE_RESET;
      seen_any = 0; last_x = 0; last_y = 0; last_z = 0;
      path_len = '0; kept_stamp = '0; kept_yaw = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      for (int r = 0; r < 8; r++) test_random(65, 16, 83);
      for (int r = 0; r < 8; r++) test_random(65, 83, 16);
      for (int r = 0; r < 8; r++) test_random(65, 0, 0);
      test_backpressure();
      if (errors == 0 && waypoints_due.size() == 0) begin
         $display("pose_waypoint_decimator test passed");
      end else begin
         $display("pose_waypoint_decimator test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pwd_pkg.sv
src/pwd_ctrl.sv
src/pwd_datapath.sv
src/pose_waypoint_decimator.sv
dv/tb_pose_waypoint_decimator.sv
